>>> rtl/paf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_pkg
// Shared types and codes for the Pareto archive filter.
// ----------------------------------------------------------------------------
package paf_pkg;

  // command codes
  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // classification codes
  localparam logic [2:0] CLS_DOMINATED  = 3'd0;
  localparam logic [2:0] CLS_EQUAL      = 3'd1;
  localparam logic [2:0] CLS_TRADEOFF   = 3'd2;
  localparam logic [2:0] CLS_DOM_SOME   = 3'd3;
  localparam logic [2:0] CLS_ALL_WEAK   = 3'd4;
  localparam logic [2:0] CLS_ALL_STRONG = 3'd5;

  // configuration register indexes (paddr[2])
  localparam logic REG_MINIMIZE_MODE = 1'b0;
  localparam logic REG_MAX_ENTRIES   = 1'b1;

  // per-objective comparison from one lane
  typedef struct packed {
    logic better;
    logic worse;
  } paf_cmp_t;

  // relation of candidate to one stored entry
  typedef enum logic [2:0] {
    REL_STRONG,
    REL_WEAK,
    REL_EQUAL,
    REL_TRADE,
    REL_WDOM,
    REL_SDOM
  } paf_rel_t;

endpackage

>>> rtl/paf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_lane
// Compares one objective of the candidate with the stored entry.
// ----------------------------------------------------------------------------
module paf_lane import paf_pkg::*; #(
  parameter int VAL_WIDTH = 32
) (
  input  logic                 minimize_mode,
  input  logic [VAL_WIDTH-1:0] cand_val,
  input  logic [VAL_WIDTH-1:0] entry_val,
  output paf_cmp_t             cmp
);

  logic same;
  logic less;

  // signed compare; "better" follows the optimisation direction
  assign same       = (cand_val == entry_val);
  assign less       = ($signed(cand_val) < $signed(entry_val));
  assign cmp.better = !same && (less == minimize_mode);
  assign cmp.worse  = !same && (less != minimize_mode);

endmodule

>>> rtl/paf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_merge
// Combines the lane results into one dominance relation.
// ----------------------------------------------------------------------------
module paf_merge import paf_pkg::*; #(
  parameter int NUM_OBJ = 4
) (
  input  paf_cmp_t [NUM_OBJ-1:0] cmp,
  output paf_rel_t               rel
);

  logic [NUM_OBJ-1:0] better;
  logic [NUM_OBJ-1:0] worse;

  always_comb begin
    for (int i = 0; i < NUM_OBJ; i++) begin
      better[i] = cmp[i].better;
      worse[i]  = cmp[i].worse;
    end
  end

  // priority as in the dominance definition
  always_comb begin
    if (&better)                rel = REL_STRONG;
    else if (|better && !(|worse)) rel = REL_WEAK;
    else if (!(|worse))         rel = REL_EQUAL;
    else if (&worse)            rel = REL_SDOM;
    else if (!(|better))        rel = REL_WDOM;
    else                        rel = REL_TRADE;
  end

endmodule

>>> rtl/pareto_archive_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_archive_filter_core
// Ordered archive of non-dominated objective vectors with dominance filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   offer a candidate, read an entry, or clear the archive. Output channel
//   (out_valid / out_stall) returns one result transaction per command.
//   One comparator lane per objective plus a merging stage judges the
//   candidate against one stored entry per cycle, read from a simple
//   dual-port archive memory with registered read data.
//   An offer makes a scan pass over every held entry. A dominated or equal
//   candidate then finishes; a trade-off goes on to the append, and one
//   that dominates some or all first takes a compaction pass over the
//   memory. A read addresses the memory and then takes the registered
//   data; clear and unused commands go straight to the result.
//   One command is worked on at a time; the next is taken once the current
//   result sits in the output register, even while the receiver stalls it.
//   A stalled result holds its payload; a finished command then waits until
//   the output register frees up.
//   Reset empties the archive (count to zero, no memory sweep) and sets
//   minimize_mode to 1 and max_entries to 32.
//   Configuration: APB, minimize_mode at 0x0, max_entries at 0x4.
// ----------------------------------------------------------------------------
module pareto_archive_filter_core import paf_pkg::*; #(
  parameter int DEPTH     = 32,
  parameter int NUM_OBJ   = 4,
  parameter int VAL_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [4:0]         entry_index,
  input  logic signed [31:0] obj0,
  input  logic signed [31:0] obj1,
  input  logic signed [31:0] obj2,
  input  logic signed [31:0] obj3,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         class_code,
  output logic               accepted,
  output logic [5:0]         evicted,
  output logic               overflow,
  output logic [5:0]         entry_count,
  output logic               read_valid,
  output logic signed [31:0] read_obj0,
  output logic signed [31:0] read_obj1,
  output logic signed [31:0] read_obj2,
  output logic signed [31:0] read_obj3
);

  localparam int EW = NUM_OBJ * VAL_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 6) ? CW : 6;
  localparam int IW = (VAL_WIDTH < 32) ? VAL_WIDTH : 32;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_DECIDE  = 7'b0000100,
    S_COMPACT = 7'b0001000,
    S_APPEND  = 7'b0010000,
    S_READ    = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic       minimize_mode;
  logic [5:0] max_entries;

  // archive memory
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  // control
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] wr_ptr;
  logic          dv;
  logic [4:0]    idx_r;
  logic [EW-1:0] cand_r;
  logic [CW-1:0] n_strong;
  logic [CW-1:0] n_weak;
  logic [CW-1:0] n_equal;
  logic [CW-1:0] n_dom;

  // working result
  logic [2:0]    w_cls;
  logic          w_acc;
  logic [CW-1:0] w_ev;
  logic          w_ovf;
  logic          w_rv;
  logic [3:0][31:0] w_obj;

  logic [3:0][31:0] obj_in;
  logic [EW-1:0]    cand_in;
  logic [3:0][31:0] rd_obj;
  paf_cmp_t [NUM_OBJ-1:0] cmp;
  paf_rel_t      rel;
  logic          rel_dominates;
  logic          issue;
  logic          room;
  logic          idx_ok;
  logic [2:0]    cls_next;
  logic [CW:0]   sum_sw;
  logic [AW+4:0] idx_ext;
  logic [LW-1:0] count_ext;
  logic [LW-1:0] ev_ext;
  logic          in_take;
  logic          out_free;
  logic          cfg_we;

  // --------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimize_mode <= 1'b1;
      max_entries   <= 6'd32;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_MINIMIZE_MODE: minimize_mode <= pwdata[0];
        REG_MAX_ENTRIES:   max_entries   <= pwdata[5:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MINIMIZE_MODE: prdata = {31'd0, minimize_mode};
      REG_MAX_ENTRIES:   prdata = {26'd0, max_entries};
      default:           prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // candidate formatting: sign-extend from the input width
  assign obj_in = {obj3, obj2, obj1, obj0};

  always_comb begin
    for (int j = 0; j < NUM_OBJ; j++) begin
      cand_in[j*VAL_WIDTH +: VAL_WIDTH] = VAL_WIDTH'($signed(obj_in[j][IW-1:0]));
    end
  end

  // stored entry back to 32-bit read fields
  always_comb begin
    logic [63:0] wide;
    wide = 64'd0;
    for (int j = 0; j < 4; j++) begin
      rd_obj[j] = 32'd0;
      if (j < NUM_OBJ) begin
        wide      = 64'($signed(rd_data[j*VAL_WIDTH +: VAL_WIDTH]));
        rd_obj[j] = wide[31:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // comparator lanes and merge
  for (genvar g = 0; g < NUM_OBJ; g++) begin : g_lane
    paf_lane #(.VAL_WIDTH(VAL_WIDTH)) u_lane (
      .minimize_mode (minimize_mode),
      .cand_val      (cand_r[g*VAL_WIDTH +: VAL_WIDTH]),
      .entry_val     (rd_data[g*VAL_WIDTH +: VAL_WIDTH]),
      .cmp           (cmp[g])
    );
  end

  paf_merge #(.NUM_OBJ(NUM_OBJ)) u_merge (
    .cmp (cmp),
    .rel (rel)
  );

  assign rel_dominates = (rel == REL_STRONG) || (rel == REL_WEAK);

  // --------------------------------------------------------------------------
  // memory
  assign idx_ext = (AW+5)'(idx_r);
  assign rd_addr = (state == S_SCAN || state == S_COMPACT) ? ptr[AW-1:0]
                                                           : idx_ext[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[AW-1:0];
    mem_wdata = rd_data;
    if (state == S_COMPACT && dv && !rel_dominates) begin
      mem_we = 1'b1;
    end else if (state == S_APPEND && room) begin
      mem_we    = 1'b1;
      mem_waddr = count[AW-1:0];
      mem_wdata = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // decisions
  assign issue  = (ptr < count);
  assign room   = ((LW+1)'(count) < (LW+1)'(max_entries)) && ((LW+1)'(count) < (LW+1)'(DEPTH));
  assign idx_ok = (LW+1)'(idx_r) < (LW+1)'(count);
  assign sum_sw = (CW+1)'(n_strong) + (CW+1)'(n_weak);

  always_comb begin
    if (count == '0)                  cls_next = CLS_ALL_STRONG;
    else if (n_dom != '0)             cls_next = CLS_DOMINATED;
    else if (n_equal != '0)           cls_next = CLS_EQUAL;
    else if (n_strong == count)       cls_next = CLS_ALL_STRONG;
    else if (sum_sw == (CW+1)'(count)) cls_next = CLS_ALL_WEAK;
    else if (sum_sw != '0)            cls_next = CLS_DOM_SOME;
    else                              cls_next = CLS_TRADEOFF;
  end

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            idx_r    <= entry_index;
            cand_r   <= cand_in;
            ptr      <= '0;
            wr_ptr   <= '0;
            dv       <= 1'b0;
            n_strong <= '0;
            n_weak   <= '0;
            n_equal  <= '0;
            n_dom    <= '0;
            w_cls    <= CLS_DOMINATED;
            w_acc    <= 1'b0;
            w_ev     <= '0;
            w_ovf    <= 1'b0;
            w_rv     <= 1'b0;
            w_obj    <= '0;
            case (cmd)
              CMD_OFFER: state <= S_SCAN;
              CMD_READ:  state <= S_READ;
              CMD_CLEAR: begin
                count <= '0;
                state <= S_FIN;
              end
              default:   state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) ptr <= ptr + 1'b1;
          dv <= issue;
          if (dv) begin
            case (rel) inside
              REL_STRONG: n_strong <= n_strong + 1'b1;
              REL_WEAK:   n_weak   <= n_weak + 1'b1;
              REL_EQUAL:  n_equal  <= n_equal + 1'b1;
              REL_WDOM, REL_SDOM: n_dom <= n_dom + 1'b1;
              default:    ;
            endcase
          end
          if (!issue && !dv) state <= S_DECIDE;
        end
        S_DECIDE: begin
          w_cls  <= cls_next;
          ptr    <= '0;
          wr_ptr <= '0;
          dv     <= 1'b0;
          if (cls_next >= CLS_DOM_SOME)      state <= S_COMPACT;
          else if (cls_next == CLS_TRADEOFF) state <= S_APPEND;
          else                               state <= S_FIN;
        end
        S_COMPACT: begin
          if (issue) ptr <= ptr + 1'b1;
          dv <= issue;
          if (dv) begin
            if (rel_dominates) w_ev   <= w_ev + 1'b1;
            else               wr_ptr <= wr_ptr + 1'b1;
          end
          if (!issue && !dv) begin
            count <= wr_ptr;
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (room) begin
            count <= count + 1'b1;
            w_acc <= 1'b1;
          end else begin
            w_ovf <= 1'b1;
          end
          state <= S_FIN;
        end
        S_READ: begin
          // addresses the memory while dv is low, takes the data once dv is set
          dv <= !dv;
          if (dv) begin
            if (idx_ok) begin
              w_rv  <= 1'b1;
              w_obj <= rd_obj;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            class_code  <= w_cls;
            accepted    <= w_acc;
            evicted     <= ev_ext[5:0];
            overflow    <= w_ovf;
            entry_count <= count_ext[5:0];
            read_valid  <= w_rv;
            read_obj0   <= w_obj[0];
            read_obj1   <= w_obj[1];
            read_obj2   <= w_obj[2];
            read_obj3   <= w_obj[3];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign count_ext = LW'(count);
  assign ev_ext    = LW'(w_ev);

endmodule

>>> bench/pareto_archive_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_archive_filter_core_tb
// Self-checking bench for the Pareto archive filter: directed and random
// command transactions, a built-in archive predictor, APB set-up of mode and
// capacity between phases, random idling on both channels.
// ----------------------------------------------------------------------------
module pareto_archive_filter_core_tb;
  import paf_pkg::*;

  localparam int ARCH_DEPTH = 32;
  localparam int WATCHDOG   = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  idx;
    logic [31:0] o0, o1, o2, o3;
  } cmd_txn_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic        acc;
    logic [5:0]  ev;
    logic        ovf;
    logic [5:0]  cnt;
    logic        rv;
    logic [31:0] r0, r1, r2, r3;
  } res_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [1:0] cmd = '0;
  logic [4:0] entry_index = '0;
  logic signed [31:0] obj0 = '0, obj1 = '0, obj2 = '0, obj3 = '0;
  logic [2:0] class_code;
  logic accepted, overflow, read_valid;
  logic [5:0] evicted, entry_count;
  logic signed [31:0] read_obj0, read_obj1, read_obj2, read_obj3;

  pareto_archive_filter_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] arch [ARCH_DEPTH][4];
  int          arch_cnt;
  logic        mode_min;
  int          cap;

  cmd_txn_t pending_q[$];
  res_txn_t expected_q[$];
  int       errors = 0;
  int       send_idle = 0, recv_idle = 0; // percent
  bit       hold_send = 1'b0;
  int       quiet = 0;

  // relation: 3 strong dom, 2 weak dom, 1 equal, -1 trade, <=-2 dominated
  function automatic int relation(logic [31:0] c[4], int s);
    int better, worse;
    better = 0;
    worse = 0;
    for (int i = 0; i < 4; i++) begin
      if (c[i] != arch[s][i]) begin
        if (($signed(c[i]) < $signed(arch[s][i])) == mode_min) better++;
        else worse++;
      end
    end
    if (better == 4) return 3;
    if (better != 0 && worse == 0) return 2;
    if (worse == 0) return 1;
    if (worse == 4) return -3;
    if (better == 0) return -2;
    return -1;
  endfunction

  function automatic res_txn_t archive_update(cmd_txn_t t);
    res_txn_t r;
    logic [31:0] c[4];
    int ns, nw, ne, nd, k, lim, rel;
    bit app;
    r = '0;
    c[0] = t.o0; c[1] = t.o1; c[2] = t.o2; c[3] = t.o3;
    ns = 0; nw = 0; ne = 0; nd = 0; app = 1'b0;
    lim = cap < ARCH_DEPTH ? cap : ARCH_DEPTH;
    if (t.cmd == CMD_OFFER) begin
      for (int i = 0; i < arch_cnt; i++) begin
        rel = relation(c, i);
        if (rel == 3) ns++;
        else if (rel == 2) nw++;
        else if (rel == 1) ne++;
        else if (rel <= -2) nd++;
      end
      if (arch_cnt == 0) r.cls = CLS_ALL_STRONG;
      else if (nd != 0) r.cls = CLS_DOMINATED;
      else if (ne != 0) r.cls = CLS_EQUAL;
      else if (ns == arch_cnt) r.cls = CLS_ALL_STRONG;
      else if (ns + nw == arch_cnt) r.cls = CLS_ALL_WEAK;
      else if (ns + nw != 0) r.cls = CLS_DOM_SOME;
      else r.cls = CLS_TRADEOFF;
      if (r.cls >= CLS_DOM_SOME) begin
        k = 0;
        for (int i = 0; i < arch_cnt; i++) begin
          if (relation(c, i) >= 2) r.ev++;
          else begin
            arch[k] = arch[i];
            k++;
          end
        end
        arch_cnt = k;
        app = 1'b1;
      end else if (r.cls == CLS_TRADEOFF) app = 1'b1;
      if (app) begin
        if (arch_cnt < lim) begin
          arch[arch_cnt] = c;
          arch_cnt++;
          r.acc = 1'b1;
        end else r.ovf = 1'b1;
      end
    end else if (t.cmd == CMD_READ) begin
      if (t.idx < arch_cnt) begin
        r.rv = 1'b1;
        r.r0 = arch[t.idx][0]; r.r1 = arch[t.idx][1];
        r.r2 = arch[t.idx][2]; r.r3 = arch[t.idx][3];
      end
    end else if (t.cmd == CMD_CLEAR) arch_cnt = 0;
    r.cnt = arch_cnt[5:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(), archive_update(pending_q.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          in_valid    <= 1'b1;
          cmd         <= pending_q[0].cmd;
          entry_index <= pending_q[0].idx;
          obj0 <= pending_q[0].o0; obj1 <= pending_q[0].o1;
          obj2 <= pending_q[0].o2; obj3 <= pending_q[0].o3;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    res_txn_t got, exp_r;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("pareto_archive_filter_core regression: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = {class_code, accepted, evicted, overflow, entry_count, read_valid,
               read_obj0, read_obj1, read_obj2, read_obj3};
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result transaction %h", $realtime, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors <= errors + 1;
            $display("%0t: mismatch cls %0d/%0d acc %0d/%0d ev %0d/%0d ovf %0d/%0d",
                     $realtime, exp_r.cls, got.cls, exp_r.acc, got.acc,
                     exp_r.ev, got.ev, exp_r.ovf, got.ovf);
            $display("%0t:   cnt %0d/%0d rv %0d/%0d rd %h %h %h %h / %h %h %h %h",
                     $realtime, exp_r.cnt, got.cnt, exp_r.rv, got.rv,
                     exp_r.r0, exp_r.r1, exp_r.r2, exp_r.r3,
                     got.r0, got.r1, got.r2, got.r3);
          end
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == REG_MINIMIZE_MODE) mode_min = data[0];
    else cap = data[5:0];
  endtask

  // wait until everything sent has come back, plus drain margin
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_obj(int pool);
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $signed($urandom_range(pool)) - pool / 2;
    endcase
  endfunction

  task automatic push_item(logic [1:0] c, logic [4:0] i,
                           logic [31:0] a, logic [31:0] b,
                           logic [31:0] d, logic [31:0] e);
    cmd_txn_t t;
    t = '{cmd: c, idx: i, o0: a, o1: b, o2: d, o3: e};
    pending_q.insert(pending_q.size(), t);
  endtask

  task automatic random_items(int n);
    int r, pool;
    logic [1:0] c;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      pool = (r < 50) ? 8 : 40;
      if (r < 70) c = CMD_OFFER;
      else if (r < 88) c = CMD_READ;
      else if (r < 94) c = CMD_CLEAR;
      else c = 2'd3;
      push_item(c, $urandom_range(31), rand_obj(pool), rand_obj(pool),
                rand_obj(pool), rand_obj(pool));
    end
  endtask

  initial begin
    arch_cnt = 0;
    mode_min = 1'b1;
    cap = 32;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, dominance classes
    send_idle = 20; recv_idle = 50;
    push_item(CMD_READ, 5'd0, '0, '0, '0, '0);              // read of empty
    push_item(CMD_OFFER, 5'd0, 32'd10, 32'd10, 32'd10, 32'd10); // empty archive
    push_item(CMD_OFFER, 5'd0, 32'd10, 32'd10, 32'd10, 32'd10); // equal
    push_item(CMD_OFFER, 5'd0, 32'd20, 32'd20, 32'd20, 32'd20); // dominated
    push_item(CMD_OFFER, 5'd0, 32'd5, 32'd20, 32'd10, 32'd10);  // trade-off
    push_item(CMD_OFFER, 5'd0, 32'd10, 32'd5, 32'd10, 32'd10);  // dominates some
    push_item(CMD_OFFER, 5'd0, 32'd10, 32'd5, 32'd9, 32'd10);   // dominates some
    push_item(CMD_OFFER, 5'd0, 32'd5, 32'd5, 32'd9, 32'd10);    // all weak
    push_item(CMD_OFFER, 5'd0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000);                  // all strong
    push_item(CMD_READ, 5'd0, '0, '0, '0, '0);
    push_item(CMD_READ, 5'd31, '0, '0, '0, '0);
    push_item(CMD_OFFER, 5'd0, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 32'h0);
    push_item(CMD_READ, 5'd1, '0, '0, '0, '0);
    push_item(2'd3, 5'd31, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff);                  // unused command
    push_item(CMD_CLEAR, 5'd0, '0, '0, '0, '0);
    push_item(CMD_READ, 5'd0, '0, '0, '0, '0);
    random_items(10);

    // sender pauses mid-stream until every result is back
    while (pending_q.size() > 5) @(posedge clk);
    hold_send = 1'b1;
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    hold_send = 1'b0;
    drain();

    // maximise, small limit: overflow and refused append after eviction
    apb_write({REG_MINIMIZE_MODE, 2'b00}, 32'd0);
    apb_write({REG_MAX_ENTRIES, 2'b00}, 32'd1);
    push_item(CMD_OFFER, 5'd0, 32'd1, 32'd2, 32'd3, 32'd4);
    push_item(CMD_OFFER, 5'd0, 32'd2, 32'd1, 32'd3, 32'd4);   // overflow
    random_items(300);
    drain();

    // capacity zero refuses every append; limit below current count
    apb_write({REG_MAX_ENTRIES, 2'b00}, 32'd0);
    random_items(60);
    drain();
    send_idle = 50; recv_idle = 20;
    apb_write({REG_MINIMIZE_MODE, 2'b00}, 32'd1);
    apb_write({REG_MAX_ENTRIES, 2'b00}, 32'd63);
    random_items(400);
    drain();
    apb_write({REG_MAX_ENTRIES, 2'b00}, 32'd3);
    random_items(200);
    drain();

    send_idle = 0; recv_idle = 0;
    apb_write({REG_MINIMIZE_MODE, 2'b00}, 32'd0);
    apb_write({REG_MAX_ENTRIES, 2'b00}, 32'd32);
    random_items(400);
    drain();

    if (errors == 0 && expected_q.size() == 0)
      $display("pareto_archive_filter_core regression: pass");
    else
      $display("pareto_archive_filter_core regression: fail");
    $finish;
  end

endmodule
